>>> sv/segi_pkg.sv
// ----------------------------------------------------------------------------
// segi_pkg
// Shared types and constants of the segment intersection pipeline.
// ----------------------------------------------------------------------------
package segi_pkg;

    // Width of each crossing coordinate on the result ports.
    localparam int OUT_BITS = 24;

    // Control that rides along with every pipeline stage.
    typedef struct packed {
        logic valid;
        logic hit;
    } t_tag;

endpackage

>>> sv/segi_front.sv
// ----------------------------------------------------------------------------
// segi_front
// Edge vectors, cross products and the hit test, four register stages.
// ----------------------------------------------------------------------------
module segi_front
    import segi_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [COORD_BITS-1:0]  i_a1x,
    input  logic signed [COORD_BITS-1:0]  i_a1y,
    input  logic signed [COORD_BITS-1:0]  i_a2x,
    input  logic signed [COORD_BITS-1:0]  i_a2y,
    input  logic signed [COORD_BITS-1:0]  i_b1x,
    input  logic signed [COORD_BITS-1:0]  i_b1y,
    input  logic signed [COORD_BITS-1:0]  i_b2x,
    input  logic signed [COORD_BITS-1:0]  i_b2y,
    output t_tag                          o_tag,
    output logic signed [2*COORD_BITS+1:0] o_num,
    output logic signed [2*COORD_BITS+1:0] o_den,
    output logic signed [COORD_BITS:0]    o_dx,
    output logic signed [COORD_BITS:0]    o_dy,
    output logic signed [COORD_BITS-1:0]  o_sx,
    output logic signed [COORD_BITS-1:0]  o_sy
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam logic signed [PW-1:0] ZERO = '0;

    // stage 1: difference vectors
    t_tag                   r_s1_tag;
    logic signed [DW-1:0]   r_s1_ax, r_s1_ay, r_s1_bx, r_s1_by, r_s1_cx, r_s1_cy;
    logic signed [COORD_BITS-1:0] r_s1_sx, r_s1_sy;
    // stage 2: partial products
    t_tag                   r_s2_tag;
    logic signed [PW-1:0]   r_s2_p [6];
    logic signed [DW-1:0]   r_s2_bx, r_s2_by;
    logic signed [COORD_BITS-1:0] r_s2_sx, r_s2_sy;
    // stage 3: cross products
    t_tag                   r_s3_tag;
    logic signed [PW-1:0]   r_s3_f, r_s3_aa, r_s3_bb;
    logic signed [DW-1:0]   r_s3_bx, r_s3_by;
    logic signed [COORD_BITS-1:0] r_s3_sx, r_s3_sy;
    // stage 4: hit test and numerator
    t_tag                   r_s4_tag;
    logic signed [PW-1:0]   r_s4_num, r_s4_den;
    logic signed [DW-1:0]   r_s4_bx, r_s4_by;
    logic signed [COORD_BITS-1:0] r_s4_sx, r_s4_sy;

    logic n_inside_pos, n_inside_neg, n_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
            r_s2_tag <= '0;
            r_s3_tag <= '0;
            r_s4_tag <= '0;
        end else begin
            r_s1_tag.valid <= i_start;
            r_s1_tag.hit   <= 1'b0;
            r_s2_tag       <= r_s1_tag;
            r_s3_tag       <= r_s2_tag;
            r_s4_tag.valid <= r_s3_tag.valid;
            r_s4_tag.hit   <= r_s3_tag.valid && n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ax <= DW'(i_a2x) - DW'(i_a1x);
        r_s1_ay <= DW'(i_a2y) - DW'(i_a1y);
        r_s1_bx <= DW'(i_b2x) - DW'(i_b1x);
        r_s1_by <= DW'(i_b2y) - DW'(i_b1y);
        r_s1_cx <= DW'(i_b2x) - DW'(i_a2x);
        r_s1_cy <= DW'(i_b2y) - DW'(i_a2y);
        r_s1_sx <= i_b1x;
        r_s1_sy <= i_b1y;

        r_s2_p[0] <= PW'(r_s1_ax) * PW'(r_s1_by);
        r_s2_p[1] <= PW'(r_s1_ay) * PW'(r_s1_bx);
        r_s2_p[2] <= PW'(r_s1_ax) * PW'(r_s1_cy);
        r_s2_p[3] <= PW'(r_s1_ay) * PW'(r_s1_cx);
        r_s2_p[4] <= PW'(r_s1_bx) * PW'(r_s1_cy);
        r_s2_p[5] <= PW'(r_s1_by) * PW'(r_s1_cx);
        r_s2_bx   <= r_s1_bx;
        r_s2_by   <= r_s1_by;
        r_s2_sx   <= r_s1_sx;
        r_s2_sy   <= r_s1_sy;

        r_s3_f  <= r_s2_p[0] - r_s2_p[1];
        r_s3_aa <= r_s2_p[2] - r_s2_p[3];
        r_s3_bb <= r_s2_p[4] - r_s2_p[5];
        r_s3_bx <= r_s2_bx;
        r_s3_by <= r_s2_by;
        r_s3_sx <= r_s2_sx;
        r_s3_sy <= r_s2_sy;

        r_s4_num <= r_s3_f - r_s3_aa;
        r_s4_den <= r_s3_f;
        r_s4_bx  <= r_s3_bx;
        r_s4_by  <= r_s3_by;
        r_s4_sx  <= r_s3_sx;
        r_s4_sy  <= r_s3_sy;
    end

    // both cross products must lie in the closed range between 0 and f
    always_comb begin
        n_inside_pos = (r_s3_aa >= ZERO) && (r_s3_bb >= ZERO) &&
                       (r_s3_aa <= r_s3_f) && (r_s3_bb <= r_s3_f);
        n_inside_neg = (r_s3_aa <= ZERO) && (r_s3_bb <= ZERO) &&
                       (r_s3_aa >= r_s3_f) && (r_s3_bb >= r_s3_f);
        n_hit = (r_s3_f != ZERO) && (r_s3_f[PW-1] ? n_inside_neg : n_inside_pos);
    end

    assign o_tag = r_s4_tag;
    assign o_num = r_s4_num;
    assign o_den = r_s4_den;
    assign o_dx  = r_s4_bx;
    assign o_dy  = r_s4_by;
    assign o_sx  = r_s4_sx;
    assign o_sy  = r_s4_sy;

endmodule

>>> sv/segi_coord.sv
// ----------------------------------------------------------------------------
// segi_coord
// One crossing coordinate: scale, pipelined restoring divide, round, offset.
// ----------------------------------------------------------------------------
module segi_coord
    import segi_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_tag                           i_tag,
    input  logic signed [2*COORD_BITS+1:0] i_num,
    input  logic signed [2*COORD_BITS+1:0] i_den,
    input  logic signed [COORD_BITS:0]     i_delta,
    input  logic signed [COORD_BITS-1:0]   i_origin,
    output t_tag                           o_tag,
    output logic signed [OUT_BITS-1:0]     o_cross
);

    localparam int C   = COORD_BITS;
    localparam int DW  = C + 1;
    localparam int PW  = 2 * DW;
    localparam int MW  = 2 * C + 1;            // magnitude of num and den
    localparam int HB  = C + 1;                // low half of num magnitude
    localparam int QB  = C + FRAC_BITS + 1;    // quotient bits
    localparam int NW  = 3 * C + 1 + FRAC_BITS; // scaled dividend
    localparam int RW  = (C + FRAC_BITS + 2 > OUT_BITS) ? C + FRAC_BITS + 2 : OUT_BITS + 1;
    localparam logic signed [RW-1:0] LIM_HI = RW'((2 ** (OUT_BITS - 1)) - 1);
    localparam logic signed [RW-1:0] LIM_LO = RW'(-(2 ** (OUT_BITS - 1)));

    // stage 1: magnitudes
    t_tag                 r_s1_tag;
    logic [MW-1:0]        r_s1_nmag, r_s1_dmag;
    logic [C-1:0]         r_s1_vmag;
    logic                 r_s1_neg;
    logic signed [C-1:0]  r_s1_org;
    // stage 2: split products
    t_tag                 r_s2_tag;
    logic [2*C:0]         r_s2_pl;
    logic [2*C-1:0]       r_s2_ph;
    logic [MW-1:0]        r_s2_dmag;
    logic                 r_s2_neg;
    logic signed [C-1:0]  r_s2_org;
    // divider chain, index 0 holds the loaded dividend
    t_tag                 r_tag [QB+1];
    logic [MW-1:0]        r_rem [QB+1];
    logic [QB-1:0]        r_x   [QB+1];
    logic [MW-1:0]        r_den [QB+1];
    logic                 r_neg [QB+1];
    logic signed [C-1:0]  r_org [QB+1];
    // rounding stage
    t_tag                 r_s5_tag;
    logic [QB:0]          r_s5_q;
    logic                 r_s5_neg;
    logic signed [C-1:0]  r_s5_org;
    // output stage
    t_tag                 r_out_tag;
    logic signed [OUT_BITS-1:0] r_out_cross;

    logic signed [PW-1:0] n_nabs, n_dabs;
    logic signed [DW-1:0] n_vabs;
    logic [2*C:0]         n_pl;
    logic [2*C-1:0]       n_ph;
    logic [NW-1:0]        n_div;
    logic                 n_up;
    logic signed [RW-1:0] n_base, n_qs, n_sum, n_sat;

    always_comb begin
        n_nabs = i_num[PW-1] ? -i_num : i_num;
        n_dabs = i_den[PW-1] ? -i_den : i_den;
        n_vabs = i_delta[DW-1] ? -i_delta : i_delta;
        n_pl   = (2*C+1)'(r_s1_vmag) * (2*C+1)'(r_s1_nmag[HB-1:0]);
        n_ph   = (2*C)'(r_s1_vmag) * (2*C)'(r_s1_nmag[MW-1:HB]);
        n_div  = (NW'(r_s2_ph) << (HB + FRAC_BITS)) + (NW'(r_s2_pl) << FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
            r_s2_tag <= '0;
            r_tag[0] <= '0;
        end else begin
            r_s1_tag <= i_tag;
            r_s2_tag <= r_s1_tag;
            r_tag[0] <= r_s2_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_nmag <= n_nabs[MW-1:0];
        r_s1_dmag <= n_dabs[MW-1:0];
        r_s1_vmag <= n_vabs[C-1:0];
        r_s1_neg  <= i_delta[DW-1];
        r_s1_org  <= i_origin;

        r_s2_pl   <= n_pl;
        r_s2_ph   <= n_ph;
        r_s2_dmag <= r_s1_dmag;
        r_s2_neg  <= r_s1_neg;
        r_s2_org  <= r_s1_org;

        // the high part of the dividend is already below the divisor
        r_rem[0] <= MW'(n_div[NW-1:QB]);
        r_x[0]   <= n_div[QB-1:0];
        r_den[0] <= r_s2_dmag;
        r_neg[0] <= r_s2_neg;
        r_org[0] <= r_s2_org;
    end

    // one quotient bit per stage; dividend bits shift out as quotient bits shift in
    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [MW:0] n_rem2;
        logic        n_ge;

        always_comb begin
            n_rem2 = {r_rem[k], r_x[k][QB-1]};
            n_ge   = n_rem2 >= {1'b0, r_den[k]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k+1] <= '0;
            end else begin
                r_tag[k+1] <= r_tag[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= n_ge ? MW'(n_rem2 - {1'b0, r_den[k]}) : MW'(n_rem2);
            r_x[k+1]   <= {r_x[k][QB-2:0], n_ge};
            r_den[k+1] <= r_den[k];
            r_neg[k+1] <= r_neg[k];
            r_org[k+1] <= r_org[k];
        end
    end

    // round half away from zero: bump when twice the remainder reaches the divisor
    assign n_up = {r_rem[QB], 1'b0} >= {1'b0, r_den[QB]};

    always_comb begin
        n_base = RW'(r_s5_org) <<< FRAC_BITS;
        n_qs   = RW'(r_s5_q);
        n_sum  = r_s5_neg ? n_base - n_qs : n_base + n_qs;
        if (n_sum > LIM_HI) begin
            n_sat = LIM_HI;
        end else if (n_sum < LIM_LO) begin
            n_sat = LIM_LO;
        end else begin
            n_sat = n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_tag  <= '0;
            r_out_tag <= '0;
        end else begin
            r_s5_tag  <= r_tag[QB];
            r_out_tag <= r_s5_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_q      <= (QB+1)'(r_x[QB]) + (QB+1)'(n_up);
        r_s5_neg    <= r_neg[QB];
        r_s5_org    <= r_org[QB];
        r_out_cross <= r_s5_tag.hit ? n_sat[OUT_BITS-1:0] : '0;
    end

    assign o_tag   = r_out_tag;
    assign o_cross = r_out_cross;

endmodule

>>> sv/segment_intersection_unit.sv
// ----------------------------------------------------------------------------
// segment_intersection_unit
// Tests two line segments for a crossing and reports the crossing point.
// ----------------------------------------------------------------------------
//
//  channel   signals                                  handshake
//  --------  ---------------------------------------  ------------------------
//  item in   i_first_*, i_second_* (start/end, x/y)   start high, busy low
//  item out  o_hit, o_cross_x, o_cross_y              o_strobe, one cycle
//
//  One item enters per cycle; busy stays low. Each item passes the front
//  stages, then the restoring divider, which retires one quotient bit per
//  stage, then the rounding and output stages.
//  Reset is synchronous and clears only the valid and hit bits; no clearing pass.
//  The receiver cannot stall, so the pipeline advances every cycle.
//
// ----------------------------------------------------------------------------
module segment_intersection_unit
    import segi_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_first_start_x,
    input  logic signed [COORD_BITS-1:0] i_first_start_y,
    input  logic signed [COORD_BITS-1:0] i_first_end_x,
    input  logic signed [COORD_BITS-1:0] i_first_end_y,
    input  logic signed [COORD_BITS-1:0] i_second_start_x,
    input  logic signed [COORD_BITS-1:0] i_second_start_y,
    input  logic signed [COORD_BITS-1:0] i_second_end_x,
    input  logic signed [COORD_BITS-1:0] i_second_end_y,
    output logic                         o_strobe,
    output logic                         o_hit,
    output logic signed [OUT_BITS-1:0]   o_cross_x,
    output logic signed [OUT_BITS-1:0]   o_cross_y
);

    // front takes 4 stages, each coordinate path 5 plus one per quotient bit
    localparam int LAT = COORD_BITS + FRAC_BITS + 10;

    t_tag                           w_front_tag;
    logic signed [2*COORD_BITS+1:0] w_num, w_den;
    logic signed [COORD_BITS:0]     w_dx, w_dy;
    logic signed [COORD_BITS-1:0]   w_sx, w_sy;
    t_tag                           w_tag_x, w_tag_y;

    // pipeline never stalls, so accept every cycle
    assign busy = 1'b0;

    // edge vectors, the three cross products and the hit decision
    segi_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_a1x   (i_first_start_x),
        .i_a1y   (i_first_start_y),
        .i_a2x   (i_first_end_x),
        .i_a2y   (i_first_end_y),
        .i_b1x   (i_second_start_x),
        .i_b1y   (i_second_start_y),
        .i_b2x   (i_second_end_x),
        .i_b2y   (i_second_end_y),
        .o_tag   (w_front_tag),
        .o_num   (w_num),
        .o_den   (w_den),
        .o_dx    (w_dx),
        .o_dy    (w_dy),
        .o_sx    (w_sx),
        .o_sy    (w_sy)
    );

    // x = B1.x + b.x * (f - aa) / f, in fixed point
    segi_coord #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_coord_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (w_front_tag),
        .i_num    (w_num),
        .i_den    (w_den),
        .i_delta  (w_dx),
        .i_origin (w_sx),
        .o_tag    (w_tag_x),
        .o_cross  (o_cross_x)
    );

    // same for y; both paths share one latency and stay in lockstep
    segi_coord #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_coord_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (w_front_tag),
        .i_num    (w_num),
        .i_den    (w_den),
        .i_delta  (w_dy),
        .i_origin (w_sy),
        .o_tag    (w_tag_y),
        .o_cross  (o_cross_y)
    );

    assign o_strobe = w_tag_x.valid;
    assign o_hit    = w_tag_x.hit;

`ifndef SYNTH
    // the two coordinate paths must carry identical control
    a_paths_lockstep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tag_x == w_tag_y)
        else $error("coordinate paths out of step");

    // a result always traces back to an earlier accepted item
    a_strobe_origin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT))
        else $error("result without a matching input item");

    // a miss reports the origin as its crossing point
    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_hit) |-> (o_cross_x == '0 && o_cross_y == '0))
        else $error("nonzero crossing on a miss");

    // hit is only raised on a valid result
    a_hit_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> o_strobe)
        else $error("hit without strobe");
`endif

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for segment_intersection_unit.
// Drives segment pairs through the start/busy port with random gaps and
// back-to-back stretches: first a short table of hand-picked pairs, then
// random pairs biased toward real crossings. Every strobed result is
// checked field by field against a typed row or the in-bench predictor.
// ----------------------------------------------------------------------------
module tb
    import segi_pkg::*;
();

    localparam int COORD_BITS   = 16;
    localparam int FRAC_BITS    = 8;
    // Entry to strobe, matching LAT in the unit.
    localparam int PIPE_LATENCY = COORD_BITS + FRAC_BITS + 10;
    localparam int RANDOM_PAIRS = 850;
    localparam int MAX_GAP      = 19;
    // Slowest run: every pair waits the longest gap, plus the pipeline.
    // Take it several times over.
    localparam int CYCLE_LIMIT  = 5 * (RANDOM_PAIRS + 40) * (MAX_GAP + 1)
                                  + 10 * PIPE_LATENCY;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord a1x, a1y, a2x, a2y;
        t_coord b1x, b1y, b2x, b2y;
    } t_seg_pair;

    typedef struct packed {
        logic                       hit;
        logic signed [OUT_BITS-1:0] x;
        logic signed [OUT_BITS-1:0] y;
    } t_crossing;

    // A row of the directed table; want is used only when typed is set.
    typedef struct packed {
        t_seg_pair pair;
        logic      typed;
        t_crossing want;
    } t_stim_row;

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start   = 1'b0;
    logic   busy;
    t_coord first_start_x  = '0;
    t_coord first_start_y  = '0;
    t_coord first_end_x    = '0;
    t_coord first_end_y    = '0;
    t_coord second_start_x = '0;
    t_coord second_start_y = '0;
    t_coord second_end_x   = '0;
    t_coord second_end_y   = '0;
    logic                       o_strobe;
    logic                       o_hit;
    logic signed [OUT_BITS-1:0] o_cross_x;
    logic signed [OUT_BITS-1:0] o_cross_y;

    t_crossing pending_crossings[$];
    t_stim_row directed_rows[$];

    int  mismatches    = 0;
    int  pairs_sent    = 0;
    int  results_seen  = 0;
    int  hits_seen     = 0;
    int  cycles        = 0;
    // When set, the sender drives back to back with no gaps.
    bit  burst_mode    = 1'b0;

    segment_intersection_unit #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_first_start_x (first_start_x),
        .i_first_start_y (first_start_y),
        .i_first_end_x   (first_end_x),
        .i_first_end_y   (first_end_y),
        .i_second_start_x(second_start_x),
        .i_second_start_y(second_start_y),
        .i_second_end_x  (second_end_x),
        .i_second_end_y  (second_end_y),
        .o_strobe        (o_strobe),
        .o_hit           (o_hit),
        .o_cross_x       (o_cross_x),
        .o_cross_y       (o_cross_y)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Crossing predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] mag_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Place one coordinate: origin + delta*num/den in fixed point. The
    // quotient is formed on magnitudes, rounded half away from zero, then
    // given its sign; saturate to the output width.
    function automatic logic signed [OUT_BITS-1:0] place_coord(longint origin, longint delta,
                                                               longint num, longint den);
        logic [127:0] prod;
        logic [127:0] quo;
        logic [127:0] rem;
        logic [127:0] dmag;
        logic         neg;
        longint       r;
        longint       lim;
        dmag = 128'(mag_of(den));
        prod = (128'(mag_of(delta)) * 128'(mag_of(num))) << FRAC_BITS;
        quo  = prod / dmag;
        rem  = prod % dmag;
        if (rem >= dmag - rem)
            quo = quo + 1;
        neg = (delta < 0) != ((num < 0) != (den < 0));
        r   = origin * (longint'(1) << FRAC_BITS);
        r   = neg ? r - longint'(quo[63:0]) : r + longint'(quo[63:0]);
        lim = longint'(1) << (OUT_BITS - 1);
        if (r > lim - 1)
            r = lim - 1;
        if (r < -lim)
            r = -lim;
        return r[OUT_BITS-1:0];
    endfunction

    function automatic t_crossing crossing_of(t_seg_pair p);
        longint    ax, ay, bx, by, cx, cy;
        longint    f, aa, bb;
        t_crossing res;
        ax = longint'(p.a2x) - longint'(p.a1x);
        ay = longint'(p.a2y) - longint'(p.a1y);
        bx = longint'(p.b2x) - longint'(p.b1x);
        by = longint'(p.b2y) - longint'(p.b1y);
        cx = longint'(p.b2x) - longint'(p.a2x);
        cy = longint'(p.b2y) - longint'(p.a2y);
        f  = ax * by - ay * bx;
        aa = ax * cy - ay * cx;
        bb = bx * cy - by * cx;
        res = '0;
        // Parallel, collinear or zero-length: no hit. Otherwise both cross
        // products must sit in the closed range between 0 and f.
        if (f < 0)
            res.hit = (aa <= 0) && (bb <= 0) && (aa >= f) && (bb >= f);
        else if (f > 0)
            res.hit = (aa >= 0) && (bb >= 0) && (aa <= f) && (bb <= f);
        if (res.hit) begin
            res.x = place_coord(longint'(p.b1x), bx, f - aa, f);
            res.y = place_coord(longint'(p.b1y), by, f - aa, f);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic int pick(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    task automatic add_row(int a1x, int a1y, int a2x, int a2y,
                           int b1x, int b1y, int b2x, int b2y,
                           logic typed, logic hit, int wx, int wy);
        t_stim_row r;
        r.pair  = '{t_coord'(a1x), t_coord'(a1y), t_coord'(a2x), t_coord'(a2y),
                    t_coord'(b1x), t_coord'(b1y), t_coord'(b2x), t_coord'(b2y)};
        r.typed = typed;
        r.want  = '{hit, OUT_BITS'(wx), OUT_BITS'(wy)};
        directed_rows.insert(directed_rows.size(), r);
    endtask

    // Draw a random pair. Half are built to cross at a chosen point (with
    // endpoint touches and one-unit misses mixed in); the rest are full-range
    // noise, dense small-box pairs and parallel pairs.
    function automatic t_seg_pair make_pair();
        t_seg_pair p;
        int        mode, cx0, cy0, dx, dy, ex, ey, s1, s2, s3, s4, nudge;
        mode = pick(0, 9);
        if (mode <= 1) begin
            p = {$urandom, $urandom, $urandom, $urandom};
        end else if (mode <= 3) begin
            p = '{t_coord'(pick(-64, 63)), t_coord'(pick(-64, 63)),
                  t_coord'(pick(-64, 63)), t_coord'(pick(-64, 63)),
                  t_coord'(pick(-64, 63)), t_coord'(pick(-64, 63)),
                  t_coord'(pick(-64, 63)), t_coord'(pick(-64, 63))};
        end else if (mode <= 8) begin
            cx0 = pick(-20000, 20000);
            cy0 = pick(-20000, 20000);
            dx  = pick(-127, 127);
            dy  = pick(-127, 127);
            ex  = pick(-127, 127);
            ey  = pick(-127, 127);
            // A zero scale puts the crossing on an endpoint.
            s1  = pick(0, 100);
            s2  = pick(0, 100);
            s3  = pick(0, 100);
            s4  = pick(0, 100);
            nudge = (pick(0, 7) == 0) ? pick(-1, 1) : 0;
            p = '{t_coord'(cx0 - s1 * dx), t_coord'(cy0 - s1 * dy),
                  t_coord'(cx0 + s2 * dx), t_coord'(cy0 + s2 * dy),
                  t_coord'(cx0 - s3 * ex + nudge), t_coord'(cy0 - s3 * ey),
                  t_coord'(cx0 + s4 * ex + nudge), t_coord'(cy0 + s4 * ey)};
        end else begin
            cx0 = pick(-200, 200);
            cy0 = pick(-200, 200);
            p.a1x = t_coord'(pick(-1000, 1000));
            p.a1y = t_coord'(pick(-1000, 1000));
            p.a2x = t_coord'(pick(-1000, 1000));
            p.a2y = t_coord'(pick(-1000, 1000));
            p.b1x = p.a1x + t_coord'(cx0);
            p.b1y = p.a1y + t_coord'(cy0);
            p.b2x = p.a2x + t_coord'(cx0);
            p.b2y = p.a2y + t_coord'(cy0);
        end
        return p;
    endfunction

    // Hold off for a random gap, present the pair, and advance once the
    // unit takes it. Start stays high between back-to-back items.
    task automatic send_pair(t_seg_pair p, t_crossing want);
        int gap;
        gap = burst_mode ? 0 : pick(0, MAX_GAP);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        first_start_x  <= p.a1x;
        first_start_y  <= p.a1y;
        first_end_x    <= p.a2x;
        first_end_y    <= p.a2y;
        second_start_x <= p.b1x;
        second_start_y <= p.b1y;
        second_end_x   <= p.b2x;
        second_end_y   <= p.b2y;
        start          <= 1'b1;
        do
            @(posedge i_clk);
        while (busy);
        pending_crossings.insert(pending_crossings.size(), want);
        pairs_sent++;
    endtask

    initial begin
        t_seg_pair p;
        t_stim_row r;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Parallel, collinear and zero-length pairs never hit.
        add_row(0, 0, 10, 0, 0, 5, 10, 5, 1, 0, 0, 0);
        add_row(0, 0, 10, 10, 5, 5, 20, 20, 1, 0, 0, 0);
        add_row(3, 3, 3, 3, 0, 0, 6, 6, 1, 0, 0, 0);
        add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                1, 0, 0, 0);
        add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1, 0, 0, 0);
        // Plain X crossing at (1,1).
        add_row(0, 0, 2, 2, 0, 2, 2, 0, 1, 1, 256, 256);
        // End of the first segment touching the middle of the second.
        add_row(0, 0, 4, 0, 4, -2, 4, 2, 1, 1, 1024, 0);
        // Not parallel, but apart.
        add_row(0, 0, 1, 0, 5, -1, 5, 1, 1, 0, 0, 0);
        // Full-range diagonals and axes.
        add_row(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 0, 0, 0, 0);
        add_row(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767, 0, 0, 0, 0);
        add_row(-32768, 0, 32767, 0, 0, -32768, 0, 32767, 0, 0, 0, 0);
        add_row(32767, 32767, 32767, -32768, 32766, 0, -32768, 1, 0, 0, 0, 0);
        // Fractional crossings, including half-LSB ties of both signs.
        add_row(0, 0, 3, 0, 1, -1, 2, 2, 0, 0, 0, 0);
        add_row(0, 0, 1, 0, 0, -1, 1, 511, 0, 0, 0, 0);
        add_row(-1, 0, 0, 0, 0, -1, -1, 511, 0, 0, 0, 0);
        add_row(0, 0, 7, 3, 1, 5, 4, -6, 0, 0, 0, 0);
        // Start of the second segment on the first; T at the first's start.
        add_row(0, 0, 4, 4, 2, 2, 2, -5, 0, 0, 0, 0);
        add_row(0, 0, 9, 1, -3, -3, 3, 3, 0, 0, 0, 0);
        // Near miss with large values.
        add_row(-30000, 100, 30000, 101, 0, 102, 1, 30000, 0, 0, 0, 0);

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            send_pair(r.pair, r.typed ? r.want : crossing_of(r.pair));
        end

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            // Flip between gapped and back-to-back stretches now and then.
            if (pick(0, 39) == 0)
                burst_mode = !burst_mode;
            p = make_pair();
            send_pair(p, crossing_of(p));
        end

        // Drop start, drain the pipeline, then watch for stray strobes.
        start <= 1'b0;
        while (pending_crossings.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);

        $display("tb: %0d segment pairs driven (%0d from the table), %0d results checked",
                 pairs_sent, directed_rows.size(), results_seen);
        $display("tb: %0d crossings reported, %0d mismatches", hits_seen, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, longint got, longint want);
        $display("tb: result %0d: %s is %0d, predicted %0d", results_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_crossing want;
        if (i_rst_n && o_strobe) begin
            if (pending_crossings.size() == 0) begin
                report_mismatch("strobe with nothing pending", 1, 0);
            end else begin
                want = pending_crossings.pop_front();
                if (o_hit !== want.hit)
                    report_mismatch("hit", o_hit, want.hit);
                if (o_cross_x !== want.x)
                    report_mismatch("cross_x", o_cross_x, want.x);
                if (o_cross_y !== want.y)
                    report_mismatch("cross_y", o_cross_y, want.y);
            end
            if (o_hit === 1'b1)
                hits_seen++;
            results_seen++;
        end
    end

    // Guard against a hung pipeline.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d results pending",
                     cycles, pending_crossings.size());
            $display("simulation failed");
            $finish;
        end
    end

endmodule

>>> segment_intersection_unit.f
sv/segi_pkg.sv
sv/segi_front.sv
sv/segi_coord.sv
sv/segment_intersection_unit.sv
bench/tb.sv
